### design/rles_pkg.sv
// Package for the RGB LED effect sequencer: shared types, register codes,
// hold times and the color conversion functions. No dependencies.
`default_nettype none

package rles_pkg;

    localparam int unsigned TICK_MS_DEFAULT     = 20;
    localparam int unsigned FLIPFLOP_MS_DEFAULT = 500;

    localparam int unsigned HOLD_W      = 10;
    localparam int unsigned DUTY_W      = 8;
    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 64;

    localparam logic [2:0] REG_EFFECT_MODE      = 3'd0;
    localparam logic [2:0] REG_HUE_FIRST        = 3'd1;
    localparam logic [2:0] REG_HUE_SECOND       = 3'd2;
    localparam logic [2:0] REG_LED_ENABLE_MASK  = 3'd3;
    localparam logic [2:0] REG_BREATH_INCREMENT = 3'd4;
    localparam logic [2:0] REG_POWER_ON         = 3'd5;

    localparam logic [2:0] MODE_STATIC    = 3'd0;
    localparam logic [2:0] MODE_BREATHING = 3'd1;
    localparam logic [2:0] MODE_FLIPFLOP  = 3'd2;
    localparam logic [2:0] MODE_RAINBOW   = 3'd3;
    localparam logic [2:0] MODE_MANUAL    = 3'd4;

    localparam logic [HOLD_W-1:0] HOLD_OTA     = 10'd20;
    localparam logic [HOLD_W-1:0] HOLD_OFF     = 10'd50;
    localparam logic [HOLD_W-1:0] HOLD_STATIC  = 10'd20;
    localparam logic [HOLD_W-1:0] HOLD_RAINBOW = 10'd15;
    localparam logic [HOLD_W-1:0] HOLD_MANUAL  = 10'd20;
    localparam logic [HOLD_W-1:0] HOLD_OTHER   = 10'd30;
    localparam logic [HOLD_W-1:0] HOLD_MAX     = 10'd1000;

    localparam logic [8:0] HUE_FULL_TURN = 9'd360;
    localparam logic [8:0] RAINBOW_STEP  = 9'd3;
    localparam logic [5:0] PULSE_PHASES  = 6'd60;
    localparam logic [6:0] BREATH_MAX    = 7'd100;
    localparam logic [6:0] BREATH_MIN    = 7'd5;

    // Level times this constant, shifted right by BREATH_SHIFT, divides by 100
    // exactly for every product of an 8-bit component and a level up to 100.
    localparam logic [15:0] BREATH_RECIP = 16'd41944;
    localparam int unsigned BREATH_SHIFT = 22;
    localparam int unsigned SCALE_W      = 23;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [2:0] effect_mode;
        logic [8:0] hue_first;
        logic [8:0] hue_second;
        logic [1:0] led_enable_mask;
        logic [6:0] breath_increment;
        logic       power_on;
    } cfg_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ms;
        logic [DUTY_W-1:0] led2_blue_duty;
        logic [DUTY_W-1:0] led2_green_duty;
        logic [DUTY_W-1:0] led2_red_duty;
        logic [DUTY_W-1:0] led1_blue_duty;
        logic [DUTY_W-1:0] led1_green_duty;
        logic [DUTY_W-1:0] led1_red_duty;
    } result_t;

    function automatic rgb_t hue_to_rgb(input logic [8:0] hue);
        logic [8:0] h;
        logic [2:0] sec;
        logic [8:0] base;
        logic [5:0] rem;
        logic [9:0] up_prod;
        logic [9:0] down_prod;
        logic [7:0] x;
        rgb_t       c;
        h = (hue >= HUE_FULL_TURN) ? hue - HUE_FULL_TURN : hue;
        if (h >= 9'd300) begin
            sec = 3'd5; base = 9'd300;
        end else if (h >= 9'd240) begin
            sec = 3'd4; base = 9'd240;
        end else if (h >= 9'd180) begin
            sec = 3'd3; base = 9'd180;
        end else if (h >= 9'd120) begin
            sec = 3'd2; base = 9'd120;
        end else if (h >= 9'd60) begin
            sec = 3'd1; base = 9'd60;
        end else begin
            sec = 3'd0; base = 9'd0;
        end
        rem = 6'(h - base);
        // 255/60 equals 17/4, so the floor is a multiply by 17 and a shift.
        up_prod   = 10'd17 * {4'd0, rem};
        down_prod = 10'd17 * {4'd0, 6'(PULSE_PHASES - rem)};
        x = sec[0] ? down_prod[9:2] : up_prod[9:2];
        c = '0;
        case (sec)
            3'd0:
            begin
                c.r = 8'd255; c.g = x;
            end
            3'd1:
            begin
                c.r = x; c.g = 8'd255;
            end
            3'd2:
            begin
                c.g = 8'd255; c.b = x;
            end
            3'd3:
            begin
                c.g = x; c.b = 8'd255;
            end
            3'd4:
            begin
                c.r = x; c.b = 8'd255;
            end
            default:
            begin
                c.r = 8'd255; c.b = x;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] scale_component(input logic [7:0] c,
                                                   input logic [SCALE_W-1:0] f);
        logic [SCALE_W+7:0] prod;
        prod = {{SCALE_W{1'b0}}, c} * {8'd0, f};
        return prod[BREATH_SHIFT+7:BREATH_SHIFT];
    endfunction

    function automatic rgb_t scale_rgb(input rgb_t c, input logic [SCALE_W-1:0] f);
        rgb_t o;
        o.r = scale_component(c.r, f);
        o.g = scale_component(c.g, f);
        o.b = scale_component(c.b, f);
        return o;
    endfunction

    // Cyan pulse color for a ramp position of 0 to 10: blue is k*255/10 and
    // green is two thirds of it, both rounded down.
    function automatic rgb_t pulse_rgb(input logic [3:0] k);
        rgb_t c;
        c.r = 8'd0;
        case (k)
            4'd0:    begin c.g = 8'd0;   c.b = 8'd0;   end
            4'd1:    begin c.g = 8'd16;  c.b = 8'd25;  end
            4'd2:    begin c.g = 8'd34;  c.b = 8'd51;  end
            4'd3:    begin c.g = 8'd50;  c.b = 8'd76;  end
            4'd4:    begin c.g = 8'd68;  c.b = 8'd102; end
            4'd5:    begin c.g = 8'd84;  c.b = 8'd127; end
            4'd6:    begin c.g = 8'd102; c.b = 8'd153; end
            4'd7:    begin c.g = 8'd118; c.b = 8'd178; end
            4'd8:    begin c.g = 8'd136; c.b = 8'd204; end
            4'd9:    begin c.g = 8'd152; c.b = 8'd229; end
            4'd10:   begin c.g = 8'd170; c.b = 8'd255; end
            default: begin c.g = 8'd0;   c.b = 8'd0;   end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/rles_cfg_regs.sv
// Configuration register file of the RGB LED effect sequencer behind an APB-style port.
// Depends on rles_pkg for register codes and the configuration struct.
`default_nettype none

module rles_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [rles_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [rles_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [rles_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                      pready,
    output rles_pkg::cfg_t                            cfg
);

    rles_pkg::cfg_t cfg_reg;
    rles_pkg::cfg_t cfg_next;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                rles_pkg::REG_EFFECT_MODE:      cfg_next.effect_mode      = pwdata[2:0];
                rles_pkg::REG_HUE_FIRST:        cfg_next.hue_first        = pwdata[8:0];
                rles_pkg::REG_HUE_SECOND:       cfg_next.hue_second       = pwdata[8:0];
                rles_pkg::REG_LED_ENABLE_MASK:  cfg_next.led_enable_mask  = pwdata[1:0];
                rles_pkg::REG_BREATH_INCREMENT: cfg_next.breath_increment = pwdata[6:0];
                rles_pkg::REG_POWER_ON:         cfg_next.power_on         = pwdata[0];
                default:                        cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            rles_pkg::REG_EFFECT_MODE:      prdata = {29'd0, cfg_reg.effect_mode};
            rles_pkg::REG_HUE_FIRST:        prdata = {23'd0, cfg_reg.hue_first};
            rles_pkg::REG_HUE_SECOND:       prdata = {23'd0, cfg_reg.hue_second};
            rles_pkg::REG_LED_ENABLE_MASK:  prdata = {30'd0, cfg_reg.led_enable_mask};
            rles_pkg::REG_BREATH_INCREMENT: prdata = {25'd0, cfg_reg.breath_increment};
            rles_pkg::REG_POWER_ON:         prdata = {31'd0, cfg_reg.power_on};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effect_mode      <= rles_pkg::MODE_STATIC;
            cfg_reg.hue_first        <= 9'd0;
            cfg_reg.hue_second       <= 9'd0;
            cfg_reg.led_enable_mask  <= 2'd3;
            cfg_reg.breath_increment <= 7'd1;
            cfg_reg.power_on         <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### design/rles_effect_engine.sv
// Effect state and per-tick color computation of the RGB LED effect sequencer.
// Depends on rles_pkg for the hue, scale and pulse functions and the result struct.
`default_nettype none

module rles_effect_engine #(
    parameter int unsigned TICK_MS     = rles_pkg::TICK_MS_DEFAULT,
    parameter int unsigned FLIPFLOP_MS = rles_pkg::FLIPFLOP_MS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rles_pkg::cfg_t  cfg,
    input  wire logic            ota,
    input  wire logic            advance,
    output rles_pkg::result_t    result
);

    localparam logic [rles_pkg::HOLD_W-1:0] HOLD_TICK = rles_pkg::HOLD_W'(TICK_MS);
    localparam logic [rles_pkg::HOLD_W-1:0] HOLD_FLIP = rles_pkg::HOLD_W'(FLIPFLOP_MS);

    logic [8:0]                  rainbow_hue_reg,  rainbow_hue_next;
    logic [6:0]                  breath_level_reg, breath_level_next;
    logic [rles_pkg::SCALE_W-1:0] breath_scale_reg, breath_scale_next;
    logic                        breath_rising_reg, breath_rising_next;
    logic                        flip_phase_reg,   flip_phase_next;
    logic [5:0]                  pulse_phase_reg,  pulse_phase_next;
    logic                        last_flag_reg;

    logic [5:0]     phase;
    logic [3:0]     ramp;
    logic [6:0]     step;
    logic [7:0]     lvl_moved;
    logic [7:0]     lvl_clamped;
    rles_pkg::rgb_t c1, c2, c_rain, c_pulse, a, b;
    logic [rles_pkg::HOLD_W-1:0] hold;

    always_comb
    begin
        phase = (ota != last_flag_reg) ? 6'd0 : pulse_phase_reg;
        if (phase < 6'd10)
        begin
            ramp = phase[3:0];
        end
        else if (phase < 6'd20)
        begin
            ramp = 4'(6'd20 - phase);
        end
        else if (phase < 6'd30)
        begin
            ramp = 4'(phase - 6'd20);
        end
        else if (phase < 6'd40)
        begin
            ramp = 4'(6'd40 - phase);
        end
        else
        begin
            ramp = 4'd0;
        end
        c_pulse = rles_pkg::pulse_rgb(ramp);
        if (ota)
        begin
            pulse_phase_next = (phase == rles_pkg::PULSE_PHASES - 6'd1) ? 6'd0 : phase + 6'd1;
        end
        else
        begin
            pulse_phase_next = phase;
        end
    end

    always_comb
    begin
        step = (cfg.breath_increment == 7'd0) ? 7'd1 : cfg.breath_increment;
        if (breath_rising_reg)
        begin
            lvl_moved = {1'b0, breath_level_reg} + {1'b0, step};
        end
        else
        begin
            lvl_moved = (breath_level_reg > step) ? {1'b0, breath_level_reg - step} : 8'd0;
        end
        lvl_clamped        = lvl_moved;
        breath_rising_next = breath_rising_reg;
        if (lvl_moved >= {1'b0, rles_pkg::BREATH_MAX})
        begin
            lvl_clamped        = {1'b0, rles_pkg::BREATH_MAX};
            breath_rising_next = 1'b0;
        end
        else if (lvl_moved <= {1'b0, rles_pkg::BREATH_MIN})
        begin
            lvl_clamped        = {1'b0, rles_pkg::BREATH_MIN};
            breath_rising_next = 1'b1;
        end
        breath_level_next = lvl_clamped[6:0];
        breath_scale_next = {16'd0, breath_level_next} * {7'd0, rles_pkg::BREATH_RECIP};
        rainbow_hue_next  = (rainbow_hue_reg >= rles_pkg::HUE_FULL_TURN - rles_pkg::RAINBOW_STEP)
                          ? rainbow_hue_reg - (rles_pkg::HUE_FULL_TURN - rles_pkg::RAINBOW_STEP)
                          : rainbow_hue_reg + rles_pkg::RAINBOW_STEP;
        flip_phase_next   = ~flip_phase_reg;
    end

    assign c1     = rles_pkg::hue_to_rgb(cfg.hue_first);
    assign c2     = rles_pkg::hue_to_rgb(cfg.hue_second);
    assign c_rain = rles_pkg::hue_to_rgb(rainbow_hue_reg);

    always_comb
    begin
        if (ota)
        begin
            a = c_pulse; b = c_pulse; hold = rles_pkg::HOLD_OTA;
        end
        else if (!cfg.power_on)
        begin
            a = '0; b = '0; hold = rles_pkg::HOLD_OFF;
        end
        else
        begin
            case (cfg.effect_mode)
                rles_pkg::MODE_STATIC:
                begin
                    a = c1; b = c2; hold = rles_pkg::HOLD_STATIC;
                end
                rles_pkg::MODE_BREATHING:
                begin
                    a    = rles_pkg::scale_rgb(c1, breath_scale_reg);
                    b    = rles_pkg::scale_rgb(c2, breath_scale_reg);
                    hold = HOLD_TICK;
                end
                rles_pkg::MODE_FLIPFLOP:
                begin
                    a    = flip_phase_reg ? '0 : c1;
                    b    = flip_phase_reg ? c2 : '0;
                    hold = HOLD_FLIP;
                end
                rles_pkg::MODE_RAINBOW:
                begin
                    a = c_rain; b = c_rain; hold = rles_pkg::HOLD_RAINBOW;
                end
                rles_pkg::MODE_MANUAL:
                begin
                    a    = cfg.led_enable_mask[0] ? c1 : '0;
                    b    = cfg.led_enable_mask[1] ? c2 : '0;
                    hold = rles_pkg::HOLD_MANUAL;
                end
                default:
                begin
                    a = c1; b = c2; hold = rles_pkg::HOLD_OTHER;
                end
            endcase
        end
        result.led1_red_duty   = ~a.r;
        result.led1_green_duty = ~a.g;
        result.led1_blue_duty  = ~a.b;
        result.led2_red_duty   = ~b.r;
        result.led2_green_duty = ~b.g;
        result.led2_blue_duty  = ~b.b;
        result.hold_ms         = hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rainbow_hue_reg   <= 9'd0;
            breath_level_reg  <= 7'd0;
            breath_scale_reg  <= '0;
            breath_rising_reg <= 1'b1;
            flip_phase_reg    <= 1'b0;
            pulse_phase_reg   <= 6'd0;
            last_flag_reg     <= 1'b0;
        end
        else if (advance)
        begin
            last_flag_reg   <= ota;
            pulse_phase_reg <= pulse_phase_next;
            if (!ota && cfg.power_on)
            begin
                if (cfg.effect_mode == rles_pkg::MODE_BREATHING)
                begin
                    breath_level_reg  <= breath_level_next;
                    breath_scale_reg  <= breath_scale_next;
                    breath_rising_reg <= breath_rising_next;
                end
                if (cfg.effect_mode == rles_pkg::MODE_FLIPFLOP)
                begin
                    flip_phase_reg <= flip_phase_next;
                end
                if (cfg.effect_mode == rles_pkg::MODE_RAINBOW)
                begin
                    rainbow_hue_reg <= rainbow_hue_next;
                end
            end
        end
    end

    a_pulse_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_phase_reg < rles_pkg::PULSE_PHASES)
        else $error("pulse phase left its range");

    a_breath_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        breath_level_reg <= rles_pkg::BREATH_MAX)
        else $error("breathing level above its maximum");

    a_breath_scale_match: assert property (@(posedge clk) disable iff (!rst_n)
        breath_scale_reg == {16'd0, breath_level_reg} * {7'd0, rles_pkg::BREATH_RECIP})
        else $error("breathing scale factor does not match the level");

    a_rainbow_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        rainbow_hue_reg < rles_pkg::HUE_FULL_TURN)
        else $error("rainbow hue left its range");

endmodule

`default_nettype wire

### design/rgb_led_effect_sequencer_core.sv
// Top level of the RGB LED effect sequencer: stream handshake, input and result
// registers. Depends on rles_pkg, rles_cfg_regs and rles_effect_engine.
//
// Usage: each transaction on the slave stream (s_tvalid, s_tready, s_tdata) is one
// effect tick; s_tdata bit 0 carries the firmware-update flag. For every tick the
// master stream (m_tvalid, m_tready, m_tdata) delivers one transaction with six
// inverted PWM duties for two RGB LEDs and the time to hold them in milliseconds.
// The effect, hues, enable mask, breathing increment and power state are set through
// the APB-style port, whose registers the user must write only while no tick is in
// flight; the block does not enforce it. A tick is captured in the input register,
// and when it advances, its colors, computed by the hue and scale logic from the
// effect state, are stored in the result register. Throughput is one tick per cycle
// unless the receiver stalls, set by that single input-to-result register stage. On
// a stall, the result is held and one more tick is taken into the input register;
// then s_tready drops until the result is taken. Reset clears both registers,
// restores the register defaults and returns the effect state to its start values.
`default_nettype none

module rgb_led_effect_sequencer_core #(
    parameter int unsigned TICK_MS     = rles_pkg::TICK_MS_DEFAULT,
    parameter int unsigned FLIPFLOP_MS = rles_pkg::FLIPFLOP_MS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rles_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [rles_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [rles_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: ota_in_progress, then zero fill.
    input  wire logic [rles_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0: led1_red_duty, led1_green_duty, led1_blue_duty,
    // led2_red_duty, led2_green_duty, led2_blue_duty, hold_ms, then zero fill.
    output logic      [rles_pkg::M_TDATA_W-1:0]    m_tdata
);

    rles_pkg::cfg_t    cfg;
    rles_pkg::result_t result;
    rles_pkg::result_t out_reg;
    logic              in_valid_reg, in_valid_next;
    logic              in_ota_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              take;

    rles_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rles_effect_engine #(
        .TICK_MS     (TICK_MS),
        .FLIPFLOP_MS (FLIPFLOP_MS)
    ) u_effect_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .ota     (in_ota_reg),
        .advance (advance),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_ota_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but tick refused");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced tick did not reach the result register");

    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.hold_ms <= rles_pkg::HOLD_MAX)
        else $error("hold time out of range");

    a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending tick dropped while the output stalled");

endmodule

`default_nettype wire

### sim/rgb_led_effect_sequencer_core_test.sv
// Self-checking testbench for rgb_led_effect_sequencer_core: a directed table, then
// random effect ticks under several register settings and stall patterns.
// Depends on rles_pkg and the RTL of the block; expected LED frames come from a local model.
module rgb_led_effect_sequencer_core_test;
    import rles_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_PHASES = 16;
    localparam int unsigned PHASE_TICKS   = 110;
    localparam int unsigned FRAME_W       = $bits(result_t);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } shade_t;

    typedef struct {
        logic       is_cfg;
        logic [2:0] idx;
        logic [31:0] value;
        logic       ota;
        logic       typed;
        result_t    golden;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Fields from bit 0: ota_in_progress, then zero fill.
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    // Fields from bit 0: led1_red_duty, led1_green_duty, led1_blue_duty,
    // led2_red_duty, led2_green_duty, led2_blue_duty, hold_ms, then zero fill.
    logic [M_TDATA_W-1:0]  m_tdata;

    // Local copy of the registers and of the effect state.
    cfg_t       led_cfg    = '{effect_mode: MODE_STATIC, hue_first: 9'd0, hue_second: 9'd0,
                               led_enable_mask: 2'd3, breath_increment: 7'd1, power_on: 1'b1};
    logic [8:0] hue_sweep  = '0;
    logic [6:0] breath_lvl = '0;
    logic       breath_up  = 1'b1;
    logic       flip_side  = 1'b0;
    logic [5:0] pulse_pos  = '0;
    logic       ota_seen   = 1'b0;

    result_t     led_frames_due[$];
    plan_row_t   directed_plan[$];
    logic        tick_typed  = 1'b0;
    result_t     tick_golden = '0;
    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned ticks_taken = 0;
    int unsigned frames_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned cycle_count = 0;
    result_t     want;
    result_t     got;
    logic [9:0]  want_field;
    logic [9:0]  got_field;

    rgb_led_effect_sequencer_core #(
        .TICK_MS     (TICK_MS_DEFAULT),
        .FLIPFLOP_MS (FLIPFLOP_MS_DEFAULT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic shade_t hue_shade(input logic [8:0] hue);
        int unsigned h;
        int unsigned sec;
        int unsigned rem;
        int unsigned ramp;
        shade_t      c;
        h    = (hue >= 9'd360) ? hue - 9'd360 : hue;
        sec  = h / 60;
        rem  = h % 60;
        ramp = (sec % 2 == 1) ? 255 * (60 - rem) / 60 : 255 * rem / 60;
        c = '0;
        case (sec)
            0:
            begin
                c.r = 8'd255; c.g = 8'(ramp);
            end
            1:
            begin
                c.r = 8'(ramp); c.g = 8'd255;
            end
            2:
            begin
                c.g = 8'd255; c.b = 8'(ramp);
            end
            3:
            begin
                c.g = 8'(ramp); c.b = 8'd255;
            end
            4:
            begin
                c.r = 8'(ramp); c.b = 8'd255;
            end
            default:
            begin
                c.r = 8'd255; c.b = 8'(ramp);
            end
        endcase
        return c;
    endfunction

    function automatic shade_t dim(input shade_t c, input int unsigned lvl);
        shade_t o;
        o.r = 8'(c.r * lvl / 100);
        o.g = 8'(c.g * lvl / 100);
        o.b = 8'(c.b * lvl / 100);
        return o;
    endfunction

    function automatic result_t pack_frame(input shade_t a, input shade_t b,
                                           input logic [HOLD_W-1:0] hold);
        result_t f;
        f.led1_red_duty   = 8'd255 - a.r;
        f.led1_green_duty = 8'd255 - a.g;
        f.led1_blue_duty  = 8'd255 - a.b;
        f.led2_red_duty   = 8'd255 - b.r;
        f.led2_green_duty = 8'd255 - b.g;
        f.led2_blue_duty  = 8'd255 - b.b;
        f.hold_ms         = hold;
        return f;
    endfunction

    function automatic result_t duties(input logic [7:0] r1, input logic [7:0] g1,
                                       input logic [7:0] b1, input logic [7:0] r2,
                                       input logic [7:0] g2, input logic [7:0] b2,
                                       input logic [HOLD_W-1:0] hold);
        result_t f;
        f.led1_red_duty   = r1;
        f.led1_green_duty = g1;
        f.led1_blue_duty  = b1;
        f.led2_red_duty   = r2;
        f.led2_green_duty = g2;
        f.led2_blue_duty  = b2;
        f.hold_ms         = hold;
        return f;
    endfunction

    // Computes the frame for one tick and advances the effect state.
    function automatic result_t next_led_frame(input logic ota);
        int unsigned p;
        int unsigned inten;
        int unsigned stp;
        int unsigned lvl;
        shade_t      c1;
        shade_t      c2;
        shade_t      k;
        shade_t      dark;
        result_t     f;
        dark = '0;
        if (ota != ota_seen)
        begin
            pulse_pos = '0;
            ota_seen  = ota;
        end
        if (ota)
        begin
            p = pulse_pos;
            if (p < 10)
                inten = p * 255 / 10;
            else if (p < 20)
                inten = (20 - p) * 255 / 10;
            else if (p < 30)
                inten = (p - 20) * 255 / 10;
            else if (p < 40)
                inten = (40 - p) * 255 / 10;
            else
                inten = 0;
            k.r = 8'd0;
            k.g = 8'(inten * 170 / 255);
            k.b = 8'(inten);
            pulse_pos = 6'((p + 1) % 60);
            return pack_frame(k, k, HOLD_OTA);
        end
        if (!led_cfg.power_on)
            return pack_frame(dark, dark, HOLD_OFF);
        c1 = hue_shade(led_cfg.hue_first);
        c2 = hue_shade(led_cfg.hue_second);
        case (led_cfg.effect_mode)
            MODE_STATIC:
                f = pack_frame(c1, c2, HOLD_STATIC);
            MODE_BREATHING:
            begin
                stp = (led_cfg.breath_increment != 0) ? led_cfg.breath_increment : 1;
                lvl = breath_lvl;
                f = pack_frame(dim(c1, lvl), dim(c2, lvl), HOLD_W'(TICK_MS_DEFAULT));
                if (breath_up)
                    lvl = lvl + stp;
                else
                    lvl = (lvl > stp) ? lvl - stp : 0;
                if (lvl >= 100)
                begin
                    lvl = 100; breath_up = 1'b0;
                end
                if (lvl <= 5)
                begin
                    lvl = 5; breath_up = 1'b1;
                end
                breath_lvl = 7'(lvl);
            end
            MODE_FLIPFLOP:
            begin
                if (flip_side)
                    f = pack_frame(dark, c2, HOLD_W'(FLIPFLOP_MS_DEFAULT));
                else
                    f = pack_frame(c1, dark, HOLD_W'(FLIPFLOP_MS_DEFAULT));
                flip_side = ~flip_side;
            end
            MODE_RAINBOW:
            begin
                k = hue_shade(hue_sweep);
                f = pack_frame(k, k, HOLD_RAINBOW);
                hue_sweep = 9'((hue_sweep + 3) % 360);
            end
            MODE_MANUAL:
                f = pack_frame(led_cfg.led_enable_mask[0] ? c1 : dark,
                               led_cfg.led_enable_mask[1] ? c2 : dark, HOLD_MANUAL);
            default:
                f = pack_frame(c1, c2, HOLD_OTHER);
        endcase
        return f;
    endfunction

    function automatic string field_label(input int i);
        case (i)
            0: return "led1_red_duty";
            1: return "led1_green_duty";
            2: return "led1_blue_duty";
            3: return "led2_red_duty";
            4: return "led2_green_duty";
            5: return "led2_blue_duty";
            default: return "hold_ms";
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic add_cfg(input logic [2:0] idx, input logic [31:0] value);
        plan_row_t row;
        row = '{is_cfg: 1'b1, idx: idx, value: value, ota: 1'b0, typed: 1'b0, golden: '0};
        directed_plan.push_back(row);
    endtask

    task automatic add_tick(input logic ota, input logic typed, input result_t golden);
        plan_row_t row;
        row = '{is_cfg: 1'b0, idx: '0, value: '0, ota: ota, typed: typed, golden: golden};
        directed_plan.push_back(row);
    endtask

    // Called at a falling edge; returns at a falling edge after the port has gone idle.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_EFFECT_MODE:      led_cfg.effect_mode      = value[2:0];
            REG_HUE_FIRST:        led_cfg.hue_first        = value[8:0];
            REG_HUE_SECOND:       led_cfg.hue_second       = value[8:0];
            REG_LED_ENABLE_MASK:  led_cfg.led_enable_mask  = value[1:0];
            REG_BREATH_INCREMENT: led_cfg.breath_increment = value[6:0];
            REG_POWER_ON:         led_cfg.power_on         = value[0];
            default:              ;
        endcase
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_tick(input logic ota, input logic typed, input result_t golden);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= S_TDATA_W'(ota);
        tick_typed  <= typed;
        tick_golden <= golden;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_frames_out();
        s_tvalid <= 1'b0;
        while (led_frames_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [8:0] pick_hue();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd359;
            2: return 9'($urandom_range(360, 511));
            default: return 9'($urandom_range(0, 359));
        endcase
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = next_led_frame(s_tdata[0]);
                if (tick_typed)
                    want = tick_golden;
                led_frames_due.push_back(want);
                ticks_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[FRAME_W-1:0];
                frames_seen++;
                if (led_frames_due.size() == 0)
                    flag_mismatch($sformatf("result %0d (%h) arrived with none expected",
                                            frames_seen, got));
                else
                begin
                    want = led_frames_due.pop_front();
                    for (int i = 0; i < 7; i++)
                    begin
                        want_field = 10'(want >> (8 * i)) & ((i == 6) ? 10'h3FF : 10'h0FF);
                        got_field  = 10'(got >> (8 * i)) & ((i == 6) ? 10'h3FF : 10'h0FF);
                        if (want_field != got_field)
                            flag_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                                    frames_seen, field_label(i),
                                                    want_field, got_field));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, led_frames_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic        ota_lvl;
        int unsigned run_left;
        logic [2:0]  mode;

        add_tick(1'b0, 1'b1, duties(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 10'd20));
        add_cfg(REG_HUE_FIRST, 32'd359);
        add_cfg(REG_HUE_SECOND, 32'd511);
        add_tick(1'b0, 1'b1, duties(8'd0, 8'd255, 8'd251, 8'd255, 8'd0, 8'd124, 10'd20));
        add_cfg(REG_POWER_ON, 32'd0);
        add_tick(1'b0, 1'b1, duties(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd50));
        // The update pulse wins over power off and starts dark.
        add_tick(1'b1, 1'b1, duties(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd20));
        repeat (3) add_tick(1'b1, 1'b0, '0);
        add_tick(1'b0, 1'b1, duties(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd50));
        add_cfg(REG_POWER_ON, 32'd1);
        add_cfg(REG_EFFECT_MODE, 32'd7);
        add_tick(1'b0, 1'b1, duties(8'd0, 8'd255, 8'd251, 8'd255, 8'd0, 8'd124, 10'd30));
        add_cfg(REG_EFFECT_MODE, 32'(MODE_BREATHING));
        add_cfg(REG_BREATH_INCREMENT, 32'd0);
        add_tick(1'b0, 1'b1, duties(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd20));
        repeat (2) add_tick(1'b0, 1'b0, '0);
        add_cfg(REG_BREATH_INCREMENT, 32'd127);
        repeat (2) add_tick(1'b0, 1'b0, '0);
        add_cfg(REG_EFFECT_MODE, 32'(MODE_FLIPFLOP));
        add_tick(1'b0, 1'b1, duties(8'd0, 8'd255, 8'd251, 8'd255, 8'd255, 8'd255, 10'd500));
        add_tick(1'b0, 1'b0, '0);
        add_cfg(REG_EFFECT_MODE, 32'(MODE_RAINBOW));
        add_tick(1'b0, 1'b1, duties(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 10'd15));
        add_tick(1'b0, 1'b0, '0);
        add_cfg(REG_EFFECT_MODE, 32'(MODE_MANUAL));
        add_cfg(REG_LED_ENABLE_MASK, 32'd0);
        add_tick(1'b0, 1'b1, duties(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd20));
        for (int m = 1; m < 4; m++)
        begin
            add_cfg(REG_LED_ENABLE_MASK, 32'(m));
            add_tick(1'b0, 1'b0, '0);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
            begin
                wait_frames_out();
                cfg_write(directed_plan[i].idx, directed_plan[i].value);
            end
            else
                send_tick(directed_plan[i].ota, directed_plan[i].typed,
                          directed_plan[i].golden);
        end

        ota_lvl  = 1'b0;
        run_left = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_frames_out();
            send_pct = 0;
            recv_pct = 0;
            mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            cfg_write(REG_EFFECT_MODE, 32'(mode));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_HUE_FIRST, 32'(pick_hue()));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_HUE_SECOND, 32'(pick_hue()));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_LED_ENABLE_MASK, 32'($urandom_range(0, 3)));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_BREATH_INCREMENT, $urandom_range(0, 1) ? 32'($urandom_range(1, 5))
                                                                     : 32'($urandom_range(0, 127)));
            if (ph == 0 || $urandom_range(0, 3) != 0)
                cfg_write(REG_POWER_ON, 32'($urandom_range(0, 9) != 0));
            case (ph % 4)
                1: send_pct = 48;
                2: recv_pct = 48;
                3:
                begin
                    send_pct = 12; recv_pct = 12;
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (run_left == 0)
                begin
                    ota_lvl  = ($urandom_range(0, 3) == 0);
                    run_left = ota_lvl ? $urandom_range(1, 90) : $urandom_range(1, 60);
                end
                run_left--;
                // A few single-tick glitches of the update flag break up the runs.
                send_tick(ota_lvl ^ ($urandom_range(0, 99) < 3), 1'b0, '0);
            end
        end
        wait_frames_out();

        $display("Covered %0d ticks and %0d results across %0d register writes,", ticks_taken,
                 frames_seen, cfg_writes);
        $display("all effects, power off and update pulses, with and without stalls on both sides.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
design/rles_pkg.sv
design/rles_cfg_regs.sv
design/rles_effect_engine.sv
design/rgb_led_effect_sequencer_core.sv
sim/rgb_led_effect_sequencer_core_test.sv
